// ===== rtl/rsti_pkg.sv =====
// Shared types and constants for the two-interval range-sum tree.
// Used by the saturating adder, the top level and the testbench.
// No dependencies.
package rsti_pkg;

    // Widths of the item fields and of the node sums.
    localparam int SUM_W = 32;
    localparam int IDX_W = 10;
    localparam int AMT_W = 16;
    localparam int CFG_W = 11;

    // Slot count after reset.
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

    // Saturation value of every node sum and result.
    localparam logic [SUM_W-1:0] SUM_MAX = 32'hFFFF_FFFF;

    // Action codes of an input item.
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef logic [SUM_W-1:0] sum_t;
    typedef logic [IDX_W-1:0] slot_t;

endpackage

// ===== rtl/range_sum_tree_two_interval.sv =====
// Top level of the two-interval range-sum tree: sequencer, node RAM and adder.
// Depends on rsti_pkg, rsti_ram and rsti_sat_add.
//
//   Channel   Signals                                           Direction
//   item      start, busy, action, slot_index, add_amount,      in (busy out)
//             first_a, last_a, first_b, last_b
//   result    done, total                                       out
//   config    cfg_wr, cfg_data                                  in
//
// A transfer of an item happens at a clock edge with start high and busy low.
// An add item makes one read and one write of the node RAM per tree level
// through the single read port.
// A query takes, per summed range, a setup step, a low and a high step per tree level
// walked and one closing step; an empty range takes the setup step only.
// After reset a clearing pass writes zero to all 2 * MAX_SLOTS nodes
// with busy high; configuration writes are taken during it.
// The result is shown for one cycle on done and total; the receiver cannot stall.
module range_sum_tree_two_interval #(
    parameter int MAX_SLOTS = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        action,
    input  rsti_pkg::slot_t             slot_index,
    input  logic [rsti_pkg::AMT_W-1:0]  add_amount,
    input  rsti_pkg::slot_t             first_a,
    input  rsti_pkg::slot_t             last_a,
    input  rsti_pkg::slot_t             first_b,
    input  rsti_pkg::slot_t             last_b,
    output logic                        done,
    output rsti_pkg::sum_t              total,
    input  logic                        cfg_wr,
    input  logic [rsti_pkg::CFG_W-1:0]  cfg_data
);

    localparam int DEPTH  = 2 * MAX_SLOTS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int POS_W  = $clog2(DEPTH + 1);
    localparam int CFG_W  = rsti_pkg::CFG_W;
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [ADDR_W-1:0] ROOT     = ADDR_W'(1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_ADD_RD,
        S_ADD_LEAF,
        S_UP_RD,
        S_UP_WR,
        S_Q_SETUP,
        S_Q_LO,
        S_Q_HI
    } state_t;

    state_t                  state_reg;
    logic [CFG_W-1:0]        slots_in_use_reg;
    logic [ADDR_W-1:0]       clr_addr_reg;
    logic [ADDR_W-1:0]       node_reg;
    logic [rsti_pkg::AMT_W-1:0] amount_reg;
    rsti_pkg::sum_t          acc_reg;
    logic                    pend_reg;
    logic [POS_W-1:0]        lo_reg;
    logic [POS_W-1:0]        hi_reg;
    rsti_pkg::slot_t         cur_first_reg;
    rsti_pkg::slot_t         cur_last_reg;
    rsti_pkg::slot_t         sec_first_reg;
    rsti_pkg::slot_t         sec_last_reg;
    logic                    have_sec_reg;
    logic                    done_reg;
    rsti_pkg::sum_t          total_reg;

    logic [CFG_W-1:0]        slot_cnt;
    logic [CFG_W-1:0]        last_clip;
    logic                    range_empty;
    logic                    overlap;
    rsti_pkg::slot_t         hull_first;
    rsti_pkg::slot_t         hull_last;

    logic                    wr_en;
    logic [ADDR_W-1:0]       wr_addr;
    rsti_pkg::sum_t          wr_data;
    logic                    rd_en;
    logic [ADDR_W-1:0]       rd_addr;
    rsti_pkg::sum_t          rd_data;
    rsti_pkg::sum_t          add_a;
    rsti_pkg::sum_t          add_b;
    rsti_pkg::sum_t          add_sum;

    // Node sum storage and the shared saturating adder.
    rsti_ram #(
        .WIDTH (rsti_pkg::SUM_W),
        .DEPTH (DEPTH)
    ) u_nodes (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    rsti_sat_add u_add (
        .a   (add_a),
        .b   (add_b),
        .sum (add_sum)
    );

    // Effective slot count: zero acts as one, large values clamp to the tree size.
    always_comb
    begin
        if (slots_in_use_reg == '0)
        begin
            slot_cnt = CFG_W'(1);
        end
        else if (32'(slots_in_use_reg) > 32'(MAX_SLOTS))
        begin
            slot_cnt = CFG_W'(MAX_SLOTS);
        end
        else
        begin
            slot_cnt = slots_in_use_reg;
        end
    end

    // Range setup: clip the last index to the slot count and test for an empty range.
    always_comb
    begin
        if (CFG_W'(cur_last_reg) > slot_cnt - CFG_W'(1))
        begin
            last_clip = slot_cnt - CFG_W'(1);
        end
        else
        begin
            last_clip = CFG_W'(cur_last_reg);
        end
        range_empty = CFG_W'(cur_first_reg) > last_clip;
    end

    // Overlap test on the raw bounds and the hull of the two intervals.
    always_comb
    begin
        overlap    = (first_a <= last_b) && (first_b <= last_a);
        hull_first = (first_a < first_b) ? first_a : first_b;
        hull_last  = (last_a > last_b) ? last_a : last_b;
    end

    // RAM port control and adder operand selection per state.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = node_reg;
        wr_data = add_sum;
        rd_en   = 1'b0;
        rd_addr = node_reg;
        add_a   = acc_reg;
        add_b   = pend_reg ? rd_data : '0;
        case (state_reg)
            S_CLEAR:
            begin
                wr_en   = 1'b1;
                wr_addr = clr_addr_reg;
                wr_data = '0;
            end
            S_ADD_RD:
            begin
                rd_en = 1'b1;
            end
            S_ADD_LEAF:
            begin
                add_a = rd_data;
                add_b = rsti_pkg::SUM_W'(amount_reg);
                wr_en = 1'b1;
            end
            S_UP_RD:
            begin
                rd_en   = (node_reg != ROOT);
                rd_addr = node_reg ^ ROOT;
            end
            S_UP_WR:
            begin
                add_b   = rd_data;
                wr_en   = 1'b1;
                wr_addr = node_reg >> 1;
            end
            S_Q_LO:
            begin
                rd_en   = (lo_reg < hi_reg) && lo_reg[0];
                rd_addr = ADDR_W'(lo_reg);
            end
            S_Q_HI:
            begin
                rd_en   = hi_reg[0];
                rd_addr = ADDR_W'(hi_reg - POS_W'(1));
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Sequencer: state, walk registers and registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            slots_in_use_reg <= rsti_pkg::CFG_RESET;
            clr_addr_reg     <= '0;
            node_reg         <= '0;
            amount_reg       <= '0;
            acc_reg          <= '0;
            pend_reg         <= 1'b0;
            lo_reg           <= '0;
            hi_reg           <= '0;
            cur_first_reg    <= '0;
            cur_last_reg     <= '0;
            sec_first_reg    <= '0;
            sec_last_reg     <= '0;
            have_sec_reg     <= 1'b0;
            done_reg         <= 1'b0;
            total_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_wr)
            begin
                slots_in_use_reg <= cfg_data;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                    if (clr_addr_reg == CLR_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        case (action)
                            rsti_pkg::ACT_ADD:
                            begin
                                if (CFG_W'(slot_index) < slot_cnt)
                                begin
                                    node_reg   <= ADDR_W'(MAX_SLOTS) + ADDR_W'(slot_index);
                                    amount_reg <= add_amount;
                                    state_reg  <= S_ADD_RD;
                                end
                            end
                            rsti_pkg::ACT_QUERY:
                            begin
                                acc_reg  <= '0;
                                pend_reg <= 1'b0;
                                if (overlap)
                                begin
                                    cur_first_reg <= hull_first;
                                    cur_last_reg  <= hull_last;
                                    have_sec_reg  <= 1'b0;
                                end
                                else
                                begin
                                    cur_first_reg <= first_a;
                                    cur_last_reg  <= last_a;
                                    sec_first_reg <= first_b;
                                    sec_last_reg  <= last_b;
                                    have_sec_reg  <= 1'b1;
                                end
                                state_reg <= S_Q_SETUP;
                            end
                            default:
                            begin
                                state_reg <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ADD_RD:
                begin
                    state_reg <= S_ADD_LEAF;
                end
                S_ADD_LEAF:
                begin
                    acc_reg   <= add_sum;
                    state_reg <= S_UP_RD;
                end
                S_UP_RD:
                begin
                    state_reg <= (node_reg == ROOT) ? S_IDLE : S_UP_WR;
                end
                S_UP_WR:
                begin
                    acc_reg   <= add_sum;
                    node_reg  <= node_reg >> 1;
                    state_reg <= S_UP_RD;
                end
                S_Q_SETUP:
                begin
                    pend_reg <= 1'b0;
                    if (range_empty)
                    begin
                        if (have_sec_reg)
                        begin
                            cur_first_reg <= sec_first_reg;
                            cur_last_reg  <= sec_last_reg;
                            have_sec_reg  <= 1'b0;
                            state_reg     <= S_Q_SETUP;
                        end
                        else
                        begin
                            total_reg <= add_sum;
                            done_reg  <= 1'b1;
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        lo_reg    <= POS_W'(MAX_SLOTS) + POS_W'(cur_first_reg);
                        hi_reg    <= POS_W'(MAX_SLOTS) + POS_W'(last_clip) + POS_W'(1);
                        state_reg <= S_Q_LO;
                    end
                end
                S_Q_LO:
                begin
                    acc_reg  <= add_sum;
                    pend_reg <= 1'b0;
                    if (lo_reg < hi_reg)
                    begin
                        pend_reg <= lo_reg[0];
                        if (lo_reg[0])
                        begin
                            lo_reg <= lo_reg + POS_W'(1);
                        end
                        state_reg <= S_Q_HI;
                    end
                    else if (have_sec_reg)
                    begin
                        cur_first_reg <= sec_first_reg;
                        cur_last_reg  <= sec_last_reg;
                        have_sec_reg  <= 1'b0;
                        state_reg     <= S_Q_SETUP;
                    end
                    else
                    begin
                        total_reg <= add_sum;
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_Q_HI:
                begin
                    acc_reg   <= add_sum;
                    pend_reg  <= hi_reg[0];
                    lo_reg    <= lo_reg >> 1;
                    hi_reg    <= hi_reg >> 1;
                    state_reg <= S_Q_LO;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign total = total_reg;

    // A result only follows the end of a query walk.
    a_done_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == S_Q_LO || $past(state_reg) == S_Q_SETUP))
        else $error("result strobe without a finished query");

    // The result strobe lasts one cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    // Queries never write the node store.
    a_query_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_SETUP || state_reg == S_Q_LO || state_reg == S_Q_HI) |-> !wr_en)
        else $error("node store written during a query");

    // The low bound never passes the high bound inside a level step.
    a_lo_le_hi: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_Q_HI) |-> (lo_reg <= hi_reg))
        else $error("range walk bounds crossed");

    // The update walk never reaches the unused node zero.
    a_node_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UP_RD || state_reg == S_UP_WR) |-> (node_reg != '0))
        else $error("update walk reached node zero");

endmodule

// ===== rtl/rsti_ram.sv =====
// Generic single-write, single-read memory with a registered read port.
// Holds the node sums of the tree. No package dependencies.
module rsti_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rsti_sat_add.sv =====
// Shared 32-bit saturating adder used for every node update and query step.
// Depends on rsti_pkg for the sum width and saturation value.
module rsti_sat_add (
    input  rsti_pkg::sum_t a,
    input  rsti_pkg::sum_t b,
    output rsti_pkg::sum_t sum
);

    logic [rsti_pkg::SUM_W:0] wide;

    // A carry out of the top bit clamps the sum to the maximum.
    always_comb
    begin
        wide = {1'b0, a} + {1'b0, b};
        sum  = wide[rsti_pkg::SUM_W] ? rsti_pkg::SUM_MAX : wide[rsti_pkg::SUM_W-1:0];
    end

endmodule

// ===== tb/range_sum_tree_two_interval_tb.sv =====
// Self-checking testbench for range_sum_tree_two_interval: slot adds and two-interval queries.
// Depends on rsti_pkg and the RTL. It keeps its own table of slot counts to predict each total.
module range_sum_tree_two_interval_tb;

    localparam int SLOT_CAP        = 1024;
    localparam int SETTLE_CYCLES   = 60;
    localparam int STALL_LIMIT     = 8000;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int DIR_ROWS        = 24;
    localparam int SHOW_LIMIT      = 10;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                    kind;
        logic                         act;
        rsti_pkg::slot_t              slot;
        logic [rsti_pkg::AMT_W-1:0]   amount;
        rsti_pkg::slot_t              fa;
        rsti_pkg::slot_t              la;
        rsti_pkg::slot_t              fb;
        rsti_pkg::slot_t              lb;
        logic [rsti_pkg::CFG_W-1:0]   cfg_val;
        logic                         has_lit;
        rsti_pkg::sum_t               lit;
    } stim_row_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic                         busy;
    logic                         action = rsti_pkg::ACT_ADD;
    rsti_pkg::slot_t              slot_index = '0;
    logic [rsti_pkg::AMT_W-1:0]   add_amount = '0;
    rsti_pkg::slot_t              first_a = '0;
    rsti_pkg::slot_t              last_a = '0;
    rsti_pkg::slot_t              first_b = '0;
    rsti_pkg::slot_t              last_b = '0;
    logic                         done;
    rsti_pkg::sum_t               total;
    logic                         cfg_wr = 1'b0;
    logic [rsti_pkg::CFG_W-1:0]   cfg_data = '0;

    // Predictor state: the count held by each slot and the slot-count register.
    rsti_pkg::sum_t               slot_tally [SLOT_CAP];
    logic [rsti_pkg::CFG_W-1:0]   slots_reg = rsti_pkg::CFG_RESET;
    rsti_pkg::sum_t               pending_totals [$];

    int                 bad_count = 0;
    int                 shown_count = 0;
    int                 quiet_cycles = 0;
    int                 sender_idle_pct = 0;
    stim_row_t          dir_table [DIR_ROWS];

    range_sum_tree_two_interval #(
        .MAX_SLOTS(SLOT_CAP)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .action     (action),
        .slot_index (slot_index),
        .add_amount (add_amount),
        .first_a    (first_a),
        .last_a     (last_a),
        .first_b    (first_b),
        .last_b     (last_b),
        .done       (done),
        .total      (total),
        .cfg_wr     (cfg_wr),
        .cfg_data   (cfg_data)
    );

    always #10 clk = ~clk;

    // Number of slots the register actually selects: zero acts as one, and the cap holds.
    function automatic int active_slots();
        if (slots_reg == '0)
            return 1;
        if (slots_reg > SLOT_CAP)
            return SLOT_CAP;
        return int'(slots_reg);
    endfunction

    // An add outside the active slots is dropped; a slot count saturates.
    function automatic void add_to_tally(int slot, int amount);
        longint unsigned grown;
        if (slot >= active_slots())
            return;
        grown = longint'(slot_tally[slot]) + amount;
        slot_tally[slot] = (grown > rsti_pkg::SUM_MAX) ? rsti_pkg::SUM_MAX
                                                       : rsti_pkg::sum_t'(grown);
    endfunction

    // Unsaturated sum over one interval, with its last index clipped to the active slots.
    function automatic longint unsigned span_sum(int first, int last);
        longint unsigned acc;
        acc = 0;
        if (last > active_slots() - 1)
            last = active_slots() - 1;
        for (int s = first; s <= last; s++)
            acc += slot_tally[s];
        return acc;
    endfunction

    // Overlapping intervals are summed over their hull, others one by one.
    function automatic rsti_pkg::sum_t query_total(int fa, int la, int fb, int lb);
        longint unsigned raw;
        if (fa <= lb && fb <= la)
            raw = span_sum((fa < fb) ? fa : fb, (la > lb) ? la : lb);
        else
            raw = span_sum(fa, la) + span_sum(fb, lb);
        return (raw > rsti_pkg::SUM_MAX) ? rsti_pkg::SUM_MAX : rsti_pkg::sum_t'(raw);
    endfunction

    // Row builders; the item fields that the action ignores get random values.
    function automatic stim_row_t add_row(int slot, int amount);
        stim_row_t r;
        r.kind    = ROW_ITEM;
        r.act     = rsti_pkg::ACT_ADD;
        r.slot    = rsti_pkg::slot_t'(slot);
        r.amount  = rsti_pkg::AMT_W'(amount);
        r.fa      = rsti_pkg::slot_t'($urandom);
        r.la      = rsti_pkg::slot_t'($urandom);
        r.fb      = rsti_pkg::slot_t'($urandom);
        r.lb      = rsti_pkg::slot_t'($urandom);
        r.cfg_val = '0;
        r.has_lit = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic stim_row_t query_row(int fa, int la, int fb, int lb);
        stim_row_t r;
        r.kind    = ROW_ITEM;
        r.act     = rsti_pkg::ACT_QUERY;
        r.slot    = rsti_pkg::slot_t'($urandom);
        r.amount  = rsti_pkg::AMT_W'($urandom);
        r.fa      = rsti_pkg::slot_t'(fa);
        r.la      = rsti_pkg::slot_t'(la);
        r.fb      = rsti_pkg::slot_t'(fb);
        r.lb      = rsti_pkg::slot_t'(lb);
        r.cfg_val = '0;
        r.has_lit = 1'b0;
        r.lit     = '0;
        return r;
    endfunction

    function automatic stim_row_t known_query(int fa, int la, int fb, int lb,
                                              rsti_pkg::sum_t lit);
        stim_row_t r;
        r = query_row(fa, la, fb, lb);
        r.has_lit = 1'b1;
        r.lit     = lit;
        return r;
    endfunction

    function automatic stim_row_t cfg_row(int value);
        stim_row_t r;
        r = add_row(0, 0);
        r.kind    = ROW_CFG;
        r.cfg_val = rsti_pkg::CFG_W'(value);
        return r;
    endfunction

    // Mostly slots inside the active range, now and then anywhere.
    function automatic int pick_slot(int eff);
        if ($urandom_range(0, 4) == 0)
            return $urandom_range(0, SLOT_CAP - 1);
        return $urandom_range(0, eff - 1);
    endfunction

    function automatic stim_row_t random_row();
        int eff;
        int a0;
        int a1;
        int b0;
        int b1;
        int swap;
        int amt;
        eff = active_slots();
        if ($urandom_range(0, 1) == 0)
        begin
            case ($urandom_range(0, 9))
                0:       amt = 0;
                1:       amt = 65535;
                default: amt = $urandom_range(0, 65535);
            endcase
            return add_row(pick_slot(eff), amt);
        end
        a0 = pick_slot(eff);
        a1 = pick_slot(eff);
        b0 = pick_slot(eff);
        b1 = pick_slot(eff);
        // Most intervals are well formed; the rest stay reversed.
        if (a0 > a1 && $urandom_range(0, 3) != 0)
        begin
            swap = a0;
            a0 = a1;
            a1 = swap;
        end
        if (b0 > b1 && $urandom_range(0, 3) != 0)
        begin
            swap = b0;
            b0 = b1;
            b1 = swap;
        end
        // Now and then the second interval starts just past the first one.
        if ($urandom_range(0, 6) == 0 && a1 < SLOT_CAP - 1)
        begin
            b0 = a1 + 1;
            b1 = b0 + $urandom_range(0, 3);
            if (b1 > SLOT_CAP - 1)
                b1 = SLOT_CAP - 1;
        end
        return query_row(a0, a1, b0, b1);
    endfunction

    function automatic int phase_slot_count(int ph);
        case (ph)
            0:       return 1024;
            1:       return 1;
            2:       return 2;
            3:       return 1025;
            4:       return 0;
            5:       return 2047;
            6:       return 37;
            7:       return $urandom_range(3, 1023);
            default: return 1024;
        endcase
    endfunction

    // Offer one item after random idle cycles and wait for its transfer.
    task automatic send_item(input stim_row_t r);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start      <= 1'b1;
        action     <= r.act;
        slot_index <= r.slot;
        add_amount <= r.amount;
        first_a    <= r.fa;
        last_a     <= r.la;
        first_b    <= r.fb;
        last_b     <= r.lb;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (r.act == rsti_pkg::ACT_ADD)
            add_to_tally(r.slot, r.amount);
        else if (r.has_lit)
            pending_totals.push_back(r.lit);
        else
            pending_totals.push_back(query_total(r.fa, r.la, r.fb, r.lb));
    endtask

    // Write the slot count once every total is in and any add has had time to finish.
    task automatic write_slot_count(input logic [rsti_pkg::CFG_W-1:0] value);
        start <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_wr   <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        slots_reg = value;
        cfg_wr   <= 1'b0;
    endtask

    // Compare each result with the oldest expected total; track cycles without a transfer.
    always @(posedge clk)
    begin : result_check
        rsti_pkg::sum_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_totals.size() == 0)
                begin
                    bad_count++;
                    if (shown_count < SHOW_LIMIT)
                    begin
                        $display("unexpected result: total %0d", total);
                        shown_count++;
                    end
                end
                else
                begin
                    want = pending_totals.pop_front();
                    if (total !== want)
                    begin
                        bad_count++;
                        if (shown_count < SHOW_LIMIT)
                        begin
                            $display("total mismatch: expected %0d, got %0d", want, total);
                            shown_count++;
                        end
                    end
                end
            end
            if ((start && !busy) || done)
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog on cycles in which nothing is transferred.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        for (int s = 0; s < SLOT_CAP; s++)
            slot_tally[s] = '0;

        // Directed rows: the register at its reset value first, then zero, too large,
        // and a shrink that hides counts until the full range comes back.
        dir_table[0]  = known_query(0, 1023, 0, 1023, 32'd0);
        dir_table[1]  = add_row(0, 65535);
        dir_table[2]  = add_row(1023, 65535);
        dir_table[3]  = add_row(512, 0);
        dir_table[4]  = known_query(0, 1023, 0, 1023, 32'd131070);
        dir_table[5]  = known_query(0, 0, 1023, 1023, 32'd131070);
        dir_table[6]  = known_query(5, 3, 1023, 1023, 32'd65535);
        dir_table[7]  = known_query(1023, 0, 1023, 0, 32'd0);
        dir_table[8]  = add_row(100, 7);
        dir_table[9]  = query_row(0, 200, 100, 1023);
        dir_table[10] = query_row(50, 150, 100, 300);
        dir_table[11] = cfg_row(0);
        dir_table[12] = known_query(0, 1023, 0, 1023, 32'd65535);
        dir_table[13] = add_row(1, 9);
        dir_table[14] = known_query(1, 5, 0, 0, 32'd65535);
        dir_table[15] = cfg_row(2047);
        dir_table[16] = query_row(0, 1023, 0, 1023);
        dir_table[17] = cfg_row(101);
        dir_table[18] = query_row(0, 1023, 900, 1000);
        dir_table[19] = add_row(101, 3);
        dir_table[20] = known_query(101, 101, 101, 101, 32'd0);
        dir_table[21] = cfg_row(1024);
        dir_table[22] = query_row(0, 1023, 0, 1023);
        dir_table[23] = query_row(1, 1, 101, 101);

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        sender_idle_pct = 17;
        foreach (dir_table[i])
        begin
            if (dir_table[i].kind == ROW_CFG)
                write_slot_count(dir_table[i].cfg_val);
            else
                send_item(dir_table[i]);
        end

        // Random phases, each under its own slot count and sender idle rate.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            write_slot_count(rsti_pkg::CFG_W'(phase_slot_count(ph)));
            sender_idle_pct = (ph < 3) ? 17 : ((ph < 6) ? 68 : 0);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_item(random_row());
        end

        start <= 1'b0;
        while (pending_totals.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        bad_count += pending_totals.size();
        if (bad_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== range_sum_tree_two_interval.f =====
rtl/rsti_pkg.sv
rtl/rsti_ram.sv
rtl/rsti_sat_add.sv
rtl/range_sum_tree_two_interval.sv
tb/range_sum_tree_two_interval_tb.sv
